[design/apra_pkg.sv]
// ----------------------------------------------------------------------------
// apra_pkg: shared types and constants of the progression range adder
// Widths, command codes, the queue entry and the state encodings used by the
// front, the queue and the back of the block.
// ----------------------------------------------------------------------------
package apra_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int ADDR_W     = $clog2(MAX_LENGTH + 1);
    localparam int IDX_W      = 11;
    localparam int LEN_W      = 11;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 64;
    localparam int DVD_W      = VAL_W + 1;
    localparam int DCNT_W     = $clog2(DVD_W);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic [IDX_W-1:0]         left;
        logic [IDX_W-1:0]         right;
        logic signed [VAL_W-1:0]  start_v;
        logic signed [VAL_W-1:0]  end_v;
        logic signed [SUM_W-1:0]  step;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // one row of the store: value differences and step differences
    typedef struct packed {
        logic [SUM_W-1:0] base;
        logic [SUM_W-1:0] slope;
    } t_row;

    typedef enum logic {
        F_IDLE,
        F_DIV
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RD,
        B_WR,
        B_SWEEP,
        B_DRAIN
    } t_back_state;

    typedef enum logic [1:0] {
        OP_LEFT,
        OP_NEXT,
        OP_END
    } t_op;

endpackage

[design/arith_progression_range_add_unit.sv]
// ----------------------------------------------------------------------------
// arith_progression_range_add_unit: progression range adder with checksum
// Adds arithmetic progressions over index ranges of a 64-bit array and on a
// finish command emits the XOR of the running sums of the array in use.
// ----------------------------------------------------------------------------
// Read first: a command is taken on a clock edge with start high and busy
// low. Results cannot be held off: o_result_valid is high for one cycle and
// o_xor_checksum must be captured then. After reset the block clears every
// row of its store while busy stays high; the length register may be
// written meanwhile. An update with left below right goes through the
// bit-serial step divider in the front; a single-position update, a dropped
// one and a finish pass the front in the cycle they are taken. Behind a
// two-entry queue the back touches up to three store rows, each by a read
// and then a write back. A finish walks one row a cycle through the read
// port and raises its checksum strobe once the last row has passed the
// accumulator pipeline; a length of zero emits 0 without a sweep. Busy also
// rises while the queue is full.
// ----------------------------------------------------------------------------
module arith_progression_range_add_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [apra_pkg::LEN_W-1:0]        i_cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic [apra_pkg::IDX_W-1:0]        i_left_index,
    input  logic [apra_pkg::IDX_W-1:0]        i_right_index,
    input  logic signed [apra_pkg::VAL_W-1:0] i_start_value,
    input  logic signed [apra_pkg::VAL_W-1:0] i_end_value,
    output logic                              o_result_valid,
    output logic [apra_pkg::SUM_W-1:0]        o_xor_checksum
);
    import apra_pkg::*;

    // length in use; read by the back when a finish leaves the queue
    logic [LEN_W-1:0]  r_length;

    logic              push, pop, clearing;
    t_item             push_item, head_item;
    t_q_status         q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_length <= i_cfg_wdata;
        end
    end

    // front: take the beat, drop bad ranges, divide out the step
    apra_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_left_index  (i_left_index),
        .i_right_index (i_right_index),
        .i_start_value (i_start_value),
        .i_end_value   (i_end_value),
        .i_q_status    (q_status),
        .i_clearing    (clearing),
        .o_push        (push),
        .o_item        (push_item)
    );

    // hold checked commands until the back is free
    apra_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    // back: store updates and the checksum sweep
    apra_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_item         (head_item),
        .o_pop          (pop),
        .i_length       (r_length),
        .o_clearing     (clearing),
        .o_result_valid (o_result_valid),
        .o_xor_checksum (o_xor_checksum)
    );

endmodule

[design/apra_front.sv]
// ----------------------------------------------------------------------------
// apra_front: command intake, range check and step divider
// Accepts a beat, drops bad ranges, and works out the step of a progression
// with a bit-serial restoring divider before queueing the entry.
// ----------------------------------------------------------------------------
module apra_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [apra_pkg::IDX_W-1:0]     i_left_index,
    input  logic [apra_pkg::IDX_W-1:0]     i_right_index,
    input  logic signed [apra_pkg::VAL_W-1:0] i_start_value,
    input  logic signed [apra_pkg::VAL_W-1:0] i_end_value,
    input  apra_pkg::t_q_status            i_q_status,
    input  logic                           i_clearing,
    output logic                           o_push,
    output apra_pkg::t_item                o_item
);
    import apra_pkg::*;

    t_front_state             r_state, n_state;
    t_item                    r_item,  n_item;
    logic [DVD_W-1:0]         r_quo,   n_quo;
    logic [IDX_W-1:0]         r_rem,   n_rem;
    logic [IDX_W-1:0]         r_div,   n_div;
    logic                     r_neg,   n_neg;
    logic [DCNT_W-1:0]        r_cnt,   n_cnt;

    logic                     accept;
    logic                     bad_range;
    logic signed [DVD_W-1:0]  diff;
    logic [DVD_W-1:0]         diff_mag;
    logic [IDX_W:0]           trial;
    logic                     fits;
    logic [IDX_W-1:0]         div_rem;
    logic [DVD_W-1:0]         div_quo;
    logic [SUM_W-1:0]         quo_ext;

    assign busy   = (r_state != F_IDLE) || i_q_status.full || i_clearing;
    assign accept = start && !busy;

    assign bad_range = (i_left_index == '0) || (i_right_index < i_left_index)
                       || (int'(i_right_index) > MAX_LENGTH);

    assign diff     = DVD_W'(i_end_value) - DVD_W'(i_start_value);
    assign diff_mag = diff[DVD_W-1] ? DVD_W'(-diff) : DVD_W'(diff);

    // one quotient bit a cycle
    assign trial   = {r_rem, r_quo[DVD_W-1]};
    assign fits    = trial >= {1'b0, r_div};
    assign div_rem = fits ? IDX_W'(trial - {1'b0, r_div}) : IDX_W'(trial);
    assign div_quo = {r_quo[DVD_W-2:0], fits};
    assign quo_ext = SUM_W'(div_quo);

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_item  = r_item;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_item.cmd     = t_cmd'(i_command);
                    n_item.left    = i_left_index;
                    n_item.right   = i_right_index;
                    n_item.start_v = i_start_value;
                    n_item.end_v   = i_end_value;
                    n_item.step    = '0;
                    if (t_cmd'(i_command) == CMD_FINISH) begin
                        o_push = 1'b1;
                        o_item = n_item;
                    end else if (!bad_range) begin
                        if (i_left_index == i_right_index) begin
                            o_push = 1'b1;
                            o_item = n_item;
                        end else begin
                            n_quo   = diff_mag;
                            n_rem   = '0;
                            n_div   = i_right_index - i_left_index;
                            n_neg   = diff[DVD_W-1];
                            n_cnt   = '0;
                            n_state = F_DIV;
                        end
                    end
                end
            end
            F_DIV: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_cnt = r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(DVD_W - 1)) begin
                    o_push      = 1'b1;
                    o_item.step = r_neg ? -quo_ext : quo_ext;
                    n_state     = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
    end

endmodule

[design/apra_queue.sv]
// ----------------------------------------------------------------------------
// apra_queue: short entry queue between front and back
// Holds checked commands so the divider and the store sequencer stall apart.
// ----------------------------------------------------------------------------
module apra_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  apra_pkg::t_item      i_item,
    input  logic                 i_pop,
    output apra_pkg::t_item      o_item,
    output apra_pkg::t_q_status  o_status
);
    import apra_pkg::*;

    t_item              r_slot [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QPTR_W:0]    r_count, n_count;

    assign o_item         = r_slot[r_rptr];
    assign o_status.full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wptr  = i_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = i_pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

[design/apra_back.sv]
// ----------------------------------------------------------------------------
// apra_back: store sequencer and checksum sweep
// Clears the store after reset, applies updates by read-modify-write and
// walks the store for a finish, emitting the checksum.
// ----------------------------------------------------------------------------
module apra_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  apra_pkg::t_q_status          i_q_status,
    input  apra_pkg::t_item              i_item,
    output logic                         o_pop,
    input  logic [apra_pkg::LEN_W-1:0]   i_length,
    output logic                         o_clearing,
    output logic                         o_result_valid,
    output logic [apra_pkg::SUM_W-1:0]   o_xor_checksum
);
    import apra_pkg::*;

    t_row                r_store [0:MAX_LENGTH];
    t_row                r_rd;

    t_back_state         r_state, n_state;
    logic [ADDR_W-1:0]   r_addr,  n_addr;
    t_op                 r_op,    n_op;
    t_item               r_item,  n_item;
    logic [ADDR_W-1:0]   r_last_addr;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    t_row                mem_wd;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_ra;

    logic                op_en;
    logic [ADDR_W-1:0]   op_addr;
    logic [SUM_W-1:0]    op_db;
    logic [SUM_W-1:0]    op_dc;
    logic [ADDR_W-1:0]   len_eff;

    logic                sweep_issue, sweep_last, start_sweep, emit_zero;

    logic                r_rd_vld, r_rd_last;
    logic                r_v1, r_l1, r_v2, r_l2, r_v3, r_l3;
    logic [SUM_W-1:0]    r_runc, r_b1, r_sv, r_run, r_acc;
    logic                r_res_valid;
    logic [SUM_W-1:0]    r_res;

    function automatic t_op next_op(input t_op op);
        t_op nxt;
        case (op)
            OP_LEFT: nxt = OP_NEXT;
            OP_NEXT: nxt = OP_END;
            default: nxt = OP_END;
        endcase
        return nxt;
    endfunction

    assign o_clearing     = (r_state == B_CLEAR);
    assign o_result_valid = r_res_valid;
    assign o_xor_checksum = r_res;

    assign len_eff = (int'(i_length) > MAX_LENGTH) ? ADDR_W'(MAX_LENGTH) : ADDR_W'(i_length);

    always_comb begin
        op_en   = 1'b0;
        op_addr = ADDR_W'(r_item.left);
        op_db   = '0;
        op_dc   = '0;
        case (r_op)
            OP_LEFT: begin
                op_en = 1'b1;
                op_db = SUM_W'(r_item.start_v);
            end
            OP_NEXT: begin
                op_en   = (r_item.left != r_item.right);
                op_addr = ADDR_W'(r_item.left) + ADDR_W'(1);
                op_dc   = r_item.step;
            end
            OP_END: begin
                op_en   = (int'(r_item.right) < MAX_LENGTH);
                op_addr = ADDR_W'(r_item.right) + ADDR_W'(1);
                op_db   = -SUM_W'(r_item.end_v);
                op_dc   = -r_item.step;
            end
            default: begin
                op_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_op        = r_op;
        n_item      = r_item;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_addr;
        mem_wd      = '0;
        mem_re      = 1'b0;
        mem_ra      = r_addr;
        sweep_issue = 1'b0;
        sweep_last  = 1'b0;
        start_sweep = 1'b0;
        emit_zero   = 1'b0;
        case (r_state)
            B_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(MAX_LENGTH)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    if (i_item.cmd == CMD_FINISH) begin
                        if (len_eff == '0) begin
                            emit_zero = 1'b1;
                        end else begin
                            start_sweep = 1'b1;
                            n_addr      = ADDR_W'(1);
                            n_state     = B_SWEEP;
                        end
                    end else begin
                        n_op    = OP_LEFT;
                        n_state = B_RD;
                    end
                end
            end
            B_RD: begin
                if (op_en) begin
                    mem_re  = 1'b1;
                    mem_ra  = op_addr;
                    n_state = B_WR;
                end else if (r_op == OP_END) begin
                    n_state = B_IDLE;
                end else begin
                    n_op = next_op(r_op);
                end
            end
            B_WR: begin
                mem_we      = 1'b1;
                mem_wa      = op_addr;
                mem_wd.base = r_rd.base + op_db;
                mem_wd.slope = r_rd.slope + op_dc;
                if (r_op == OP_END) begin
                    n_state = B_IDLE;
                end else begin
                    n_op    = next_op(r_op);
                    n_state = B_RD;
                end
            end
            B_SWEEP: begin
                mem_re      = 1'b1;
                sweep_issue = 1'b1;
                if (r_addr == r_last_addr) begin
                    sweep_last = 1'b1;
                    n_state    = B_DRAIN;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            B_DRAIN: begin
                if (r_v3 && r_l3) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_v1        <= 1'b0;
            r_l1        <= 1'b0;
            r_v2        <= 1'b0;
            r_l2        <= 1'b0;
            r_v3        <= 1'b0;
            r_l3        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_rd_vld    <= sweep_issue;
            r_rd_last   <= sweep_last;
            r_v1        <= r_rd_vld;
            r_l1        <= r_rd_last;
            r_v2        <= r_v1;
            r_l2        <= r_l1;
            r_v3        <= r_v2;
            r_l3        <= r_l2;
            r_res_valid <= (r_v3 && r_l3) || emit_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_item <= n_item;
        if (start_sweep) begin
            r_last_addr <= len_eff;
            r_runc      <= '0;
            r_run       <= '0;
            r_acc       <= '0;
        end else begin
            if (r_rd_vld) begin
                r_runc <= r_runc + r_rd.slope;
                r_b1   <= r_rd.base;
            end
            if (r_v1) begin
                r_sv <= r_b1 + r_runc;
            end
            if (r_v2) begin
                r_run <= r_run + r_sv;
            end
            if (r_v3) begin
                r_acc <= r_acc ^ r_run;
            end
        end
        r_res <= emit_zero ? '0 : (r_acc ^ r_run);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= r_store[mem_ra];
        end
    end

endmodule

[design/apra_checker.sv]
// ----------------------------------------------------------------------------
// apra_checker: port-level checks of the progression range adder
// Watches reset, busy and the result strobe on the top level.
// ----------------------------------------------------------------------------
module apra_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          i_command,
    input  logic [apra_pkg::IDX_W-1:0]    i_left_index,
    input  logic [apra_pkg::IDX_W-1:0]    i_right_index,
    input  logic                          o_result_valid
);
    import apra_pkg::*;

    // the store clear holds off commands after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // no result straight out of reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe right after reset");

    // a ranged update occupies the divider on the next cycle
    a_divide_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_ADD) && (i_left_index != '0)
         && (i_right_index > i_left_index) && (int'(i_right_index) <= MAX_LENGTH))
        |=> busy)
        else $error("busy low while dividing");

endmodule

bind arith_progression_range_add_unit apra_checker u_apra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_command      (i_command),
    .i_left_index   (i_left_index),
    .i_right_index  (i_right_index),
    .o_result_valid (o_result_valid)
);

[bench/tb_arith_progression_range_add_unit.sv]
// ----------------------------------------------------------------------------
// tb_arith_progression_range_add_unit: self-checking bench of the range adder
// Feeds add and finish beats through the start/busy handshake, keeps its own
// difference array and length register, and checks every emitted checksum
// against the value it worked out when the finish beat was taken.
// ----------------------------------------------------------------------------
module tb_arith_progression_range_add_unit;
    import apra_pkg::*;

    // Cycles to let queued updates drain once the last checksum has come:
    // one update in the divider, two in the queue, up to three store rows each.
    localparam int SETTLE_CYCLES  = 200;
    // Longest run of cycles with no beat, result or register write that a
    // correct block can show: clearing pass, or a few full-length finishes.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_BEATS   = 950;
    // Window of driven beats in which the sender inserts no random gaps.
    localparam int BURST_FIRST    = 300;
    localparam int BURST_LAST     = 420;

    typedef enum logic [1:0] {
        ENTRY_BEAT,
        ENTRY_LENGTH,
        ENTRY_DRAIN
    } t_entry_kind;

    typedef struct {
        t_entry_kind             kind;
        t_cmd                    cmd;
        logic [IDX_W-1:0]        left;
        logic [IDX_W-1:0]        right;
        logic signed [VAL_W-1:0] start_v;
        logic signed [VAL_W-1:0] end_v;
        logic [LEN_W-1:0]        length;
    } t_work;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [LEN_W-1:0]        i_cfg_wdata    = '0;
    logic                    start          = 1'b0;
    logic                    busy;
    logic                    i_command      = 1'b0;
    logic [IDX_W-1:0]        i_left_index   = '0;
    logic [IDX_W-1:0]        i_right_index  = '0;
    logic signed [VAL_W-1:0] i_start_value  = '0;
    logic signed [VAL_W-1:0] i_end_value    = '0;
    logic                    o_result_valid;
    logic [SUM_W-1:0]        o_xor_checksum;

    // Work for the sender: beats, length writes and drain pauses, in order.
    t_work            work_list[$];
    // Checksums owed by the block, oldest first.
    logic [SUM_W-1:0] checksums_due[$];
    // Shadow of the block: difference rows and the length register.
    logic [SUM_W-1:0] diff_rows [1:MAX_LENGTH];
    logic [LEN_W-1:0] live_length;

    logic took_beat    = 1'b0;
    int   quiet_cycles = 0;
    int   sent_beats   = 0;
    int   stall_cycles = 0;
    int   mismatches   = 0;

    always #2 i_clk = ~i_clk;

    arith_progression_range_add_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_left_index   (i_left_index),
        .i_right_index  (i_right_index),
        .i_start_value  (i_start_value),
        .i_end_value    (i_end_value),
        .o_result_valid (o_result_valid),
        .o_xor_checksum (o_xor_checksum)
    );

    // ------------------------------------------------------------------------
    // Shadow arithmetic
    // ------------------------------------------------------------------------

    // Add start at left, the truncated step on left+1..right and take end off
    // just past the range. Drop bad ranges, as the block does.
    function automatic void add_progression(input logic [IDX_W-1:0] lo,
                                            input logic [IDX_W-1:0] hi,
                                            input int sv, input int ev);
        longint step;
        int     k;
        if (lo == 0 || hi < lo || hi > MAX_LENGTH)
            return;
        step = 0;
        // 64-bit difference, division truncates toward zero
        if (hi != lo)
            step = (longint'(ev) - longint'(sv)) / longint'(hi - lo);
        for (k = lo + 1; k <= hi; k++)
            diff_rows[k] = diff_rows[k] + step;
        diff_rows[lo] = diff_rows[lo] + longint'(sv);
        // no row exists past the top, so drop the closing entry there
        if (hi < MAX_LENGTH)
            diff_rows[hi + 1] = diff_rows[hi + 1] - longint'(ev);
    endfunction

    // XOR of the running sums over the positions in use; clamp the length.
    function automatic logic [SUM_W-1:0] checksum_of_store();
        logic [SUM_W-1:0] run;
        logic [SUM_W-1:0] acc;
        int               n;
        int               k;
        n   = (live_length > MAX_LENGTH) ? MAX_LENGTH : live_length;
        run = '0;
        acc = '0;
        for (k = 1; k <= n; k++) begin
            run = run + diff_rows[k];
            acc = acc ^ run;
        end
        return acc;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Bias towards the extremes of a signed 32-bit value.
    function automatic int pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return int'($urandom_range(40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_add(input int unsigned lo, input int unsigned hi,
                            input int sv, input int ev);
        t_work w;
        w.kind    = ENTRY_BEAT;
        w.cmd     = CMD_ADD;
        w.left    = IDX_W'(lo);
        w.right   = IDX_W'(hi);
        w.start_v = sv;
        w.end_v   = ev;
        w.length  = '0;
        work_list.push_back(w);
    endtask

    // Fill the ignored fields of a finish with noise.
    task automatic push_finish();
        t_work w;
        w.kind    = ENTRY_BEAT;
        w.cmd     = CMD_FINISH;
        w.left    = IDX_W'($urandom);
        w.right   = IDX_W'($urandom);
        w.start_v = $urandom;
        w.end_v   = $urandom;
        w.length  = '0;
        work_list.push_back(w);
    endtask

    task automatic push_length(input int unsigned n);
        t_work w;
        w.kind    = ENTRY_LENGTH;
        w.cmd     = CMD_ADD;
        w.left    = '0;
        w.right   = '0;
        w.start_v = '0;
        w.end_v   = '0;
        w.length  = LEN_W'(n);
        work_list.push_back(w);
    endtask

    task automatic push_drain();
        t_work w;
        w.kind    = ENTRY_DRAIN;
        w.cmd     = CMD_ADD;
        w.left    = '0;
        w.right   = '0;
        w.start_v = '0;
        w.end_v   = '0;
        w.length  = '0;
        work_list.push_back(w);
    endtask

    // ------------------------------------------------------------------------
    // Sender: one change of each input per falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic drive_start;
        logic drive_we;
        logic gap;
        // hold a beat that was not taken at the last rising edge
        drive_start = start && !took_beat;
        drive_we    = 1'b0;
        if (i_rst_n && !drive_start && work_list.size() > 0) begin
            gap = ($urandom_range(99) < 22) &&
                  !(sent_beats >= BURST_FIRST && sent_beats < BURST_LAST);
            case (work_list[0].kind)
                ENTRY_BEAT: begin
                    if (!gap) begin
                        i_command     <= work_list[0].cmd;
                        i_left_index  <= work_list[0].left;
                        i_right_index <= work_list[0].right;
                        i_start_value <= work_list[0].start_v;
                        i_end_value   <= work_list[0].end_v;
                        drive_start    = 1'b1;
                        sent_beats    <= sent_beats + 1;
                        void'(work_list.pop_front());
                    end
                end
                // write the length only once the block has gone quiet
                ENTRY_LENGTH: begin
                    if (checksums_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                        i_cfg_wdata <= work_list[0].length;
                        drive_we     = 1'b1;
                        void'(work_list.pop_front());
                    end
                end
                ENTRY_DRAIN: begin
                    if (checksums_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                        void'(work_list.pop_front());
                end
                default: ;
            endcase
        end
        start    <= drive_start;
        i_cfg_we <= drive_we;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge, predict on accepted beats
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [SUM_W-1:0] due;
        logic             beat;
        int               k;
        if (!i_rst_n) begin
            for (k = 1; k <= MAX_LENGTH; k++)
                diff_rows[k] = '0;
            live_length   = LEN_RESET;
            took_beat    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            beat = start && !busy;
            if (i_cfg_we)
                live_length = i_cfg_wdata;
            // a result always belongs to an earlier beat, so check it first
            if (o_result_valid) begin
                if (checksums_due.size() == 0) begin
                    $error("xor_checksum: expected none, actual %h", o_xor_checksum);
                    mismatches++;
                end else begin
                    due = checksums_due.pop_front();
                    if (o_xor_checksum !== due) begin
                        $error("xor_checksum: expected %h, actual %h", due, o_xor_checksum);
                        mismatches++;
                    end
                end
            end
            if (beat) begin
                if (i_command == CMD_FINISH)
                    checksums_due.push_back(checksum_of_store());
                else
                    add_progression(i_left_index, i_right_index,
                                    i_start_value, i_end_value);
            end
            took_beat    <= beat;
            quiet_cycles <= (beat || o_result_valid) ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || i_cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int          counted;
        int unsigned lo;
        int unsigned hi;
        int unsigned roll;

        // Directed: full range at the value extremes, single position,
        // top position, inexact and negative steps, bad ranges.
        push_add(1, 1024, 32'sh8000_0000, 32'sh7fff_ffff);
        push_add(1, 1, 32'sh7fff_ffff, 32'sh8000_0000);
        push_add(1024, 1024, -1, -1);
        push_add(5, 9, 10, 3);
        push_add(2, 1023, 32'sh7fff_ffff, 32'sh8000_0000);
        push_add(0, 5, 77, 88);
        push_add(9, 8, 1, 2);
        push_add(1000, 2047, 5, 6);
        push_add(1500, 2000, -5, 6);
        push_finish();
        push_add(700, 1000, 123456, -654321);
        push_finish();
        // hold the sender until the block has answered everything
        push_drain();
        // length zero, oversized length, one position
        push_length(0);
        push_finish();
        push_length(2047);
        push_finish();
        push_length(1);
        push_finish();
        // update beyond the length in use, then raise the length over it
        push_length(3);
        push_add(1000, 1024, 42, -42);
        push_finish();
        push_length(1024);
        push_finish();

        // Random phases: a length setting, then mostly well-formed updates
        // with finishes among them and some dropped ranges as noise.
        counted = 0;
        while (counted < RANDOM_BEATS) begin
            case ($urandom_range(9))
                0:       push_length(1024);
                1:       push_length($urandom_range(2047));
                2:       push_length($urandom_range(4, 1));
                default: push_length($urandom_range(64, 1));
            endcase
            repeat ($urandom_range(60, 30)) begin
                roll = $urandom_range(99);
                if (roll < 14) begin
                    push_finish();
                    counted++;
                end else if (roll < 19) begin
                    // noise: left zero, reversed range, or right past the top
                    case ($urandom_range(2))
                        0: push_add(0, $urandom_range(2047), pick_value(), pick_value());
                        1: begin
                            lo = $urandom_range(2047, 2);
                            push_add(lo, $urandom_range(lo - 1), pick_value(), pick_value());
                        end
                        default: begin
                            hi = $urandom_range(2047, MAX_LENGTH + 1);
                            push_add($urandom_range(hi, 1), hi, pick_value(), pick_value());
                        end
                    endcase
                end else begin
                    // keep half of the ranges near the positions in use
                    if ($urandom_range(1)) begin
                        lo = $urandom_range(72, 1);
                        hi = lo + $urandom_range(16);
                    end else begin
                        lo = $urandom_range(MAX_LENGTH, 1);
                        hi = $urandom_range(MAX_LENGTH, lo);
                    end
                    if ($urandom_range(9) == 0)
                        hi = lo;
                    push_add(lo, hi, pick_value(), pick_value());
                    counted++;
                end
                if ($urandom_range(99) < 2)
                    push_drain();
            end
            push_finish();
            counted++;
        end

        // single reset at the start of the run
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // drain: all work sent, all checksums in, then let the back settle
        while (work_list.size() != 0 || start || checksums_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
design/apra_pkg.sv
design/apra_front.sv
design/apra_queue.sv
design/apra_back.sv
design/arith_progression_range_add_unit.sv
design/apra_checker.sv
bench/tb_arith_progression_range_add_unit.sv
